/* src/assert_macros.svh */
// Assertion macros for checker files.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define CHK_IMPLY(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("check failed");
`define CHK_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("check failed");
`endif

/* src/xmht_pkg.sv */
// Package for the extended memory handle table.
// Types, codes and constants; no dependencies.
package xmht_pkg;
    localparam int HANDLE_COUNT_DEF = 128;
    localparam int PAGE_INDEX_BITS_DEF = 20;
    localparam logic [32:0] REAL_LIMIT = 33'h010FFF0;

    typedef enum logic [2:0] {
        FN_ALLOC = 3'd0, FN_FREE = 3'd1, FN_LOCK = 3'd2, FN_UNLOCK = 3'd3,
        FN_INFO = 3'd4, FN_RESIZE = 3'd5, FN_MOVE = 3'd6, FN_NONE = 3'd7
    } func_t;

    typedef enum logic [3:0] {
        ST_OK = 4'd0, ST_NO_HANDLES = 4'd1, ST_NO_SPACE = 4'd2, ST_BAD_HANDLE = 4'd3,
        ST_LOCKED = 4'd4, ST_LOCK_OVF = 4'd5, ST_NOT_LOCKED = 4'd6, ST_PARITY = 4'd7,
        ST_BAD_SRC_H = 4'd8, ST_BAD_SRC_O = 4'd9, ST_BAD_DST_H = 4'd10,
        ST_BAD_DST_O = 4'd11, ST_BAD_LEN = 4'd12
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE, S_SCAN, S_READ, S_EVAL, S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic read;
        logic eval;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic scan_done;
    } stat_t;
endpackage

/* src/xmht_ctrl.sv */
// Controller sequencing one request through the datapath.
// Depends on xmht_pkg.
module xmht_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output xmht_pkg::cmd_t  cmd,
    input  xmht_pkg::stat_t stat
);
    import xmht_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_SCAN;
            S_SCAN: if (stat.scan_done) state_next = S_READ;
            S_READ: state_next = S_EVAL;
            S_EVAL: state_next = S_OUT;
            S_OUT:  if (out_ready) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        out_valid = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_SCAN: cmd.scan = 1'b1;
            S_READ: cmd.read = 1'b1;
            S_EVAL: cmd.eval = 1'b1;
            S_OUT:
            begin
                out_valid = 1'b1;
                cmd.emit = out_ready;
            end
            default: ;
        endcase
    end
endmodule

/* src/xmht_dp.sv */
// Datapath: handle table, free-handle search and request evaluation.
// Depends on xmht_pkg.
module xmht_dp
#(
    parameter int HANDLE_COUNT = xmht_pkg::HANDLE_COUNT_DEF,
    parameter int PAGE_INDEX_BITS = xmht_pkg::PAGE_INDEX_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  xmht_pkg::cmd_t   cmd,
    output xmht_pkg::stat_t  stat,
    input  logic [255:0]     in_data,
    output logic [159:0]     out_data
);
    import xmht_pkg::*;

    localparam int LIMIT = (HANDLE_COUNT < 128) ? HANDLE_COUNT : 128;
    localparam int HW = (HANDLE_COUNT > 1) ? $clog2(HANDLE_COUNT) : 1;

    logic [HANDLE_COUNT-1:0] used_reg;
    logic [19:0] page_mem [HANDLE_COUNT];
    logic [7:0]  lock_mem [HANDLE_COUNT];
    logic [21:0] size_mem [HANDLE_COUNT];

    logic [2:0]  func_reg;
    logic [6:0]  h_reg, sh_reg, dh_reg;
    logic [21:0] size_reg;
    logic        gok_reg;
    logic [19:0] gpage_reg;
    logic [31:0] soff_reg, doff_reg, len_reg;

    logic [7:0] scan_reg;
    logic [6:0] first_reg, nfree_reg;
    logic       found_reg;

    logic [19:0] hp_reg, dp_reg;
    logic [7:0]  hl_reg;
    logic [21:0] hs_reg, ds_reg;

    logic [159:0] out_reg;

    logic [159:0] res;
    logic         wr_en, use_en, use_val;
    logic [HW-1:0] wr_h;
    logic [HW-1:0] rd_a;
    logic [19:0]  wr_page;
    logic [7:0]   wr_lock;
    logic [21:0]  wr_size;
    logic [3:0]   st;
    logic [6:0]   o_h, o_nf;
    logic [31:0]  o_base, o_dest, slim, dlim, sa, da;
    logic [7:0]   o_lock;
    logic [21:0]  o_size;
    logic [20:0]  o_pages;
    logic [19:0]  o_rel;
    logic         hv;
    logic [32:0]  rs_sum, rd_sum;

    function automatic logic hok(input logic [6:0] h, input logic [HANDLE_COUNT-1:0] u);
        logic r;
        r = 1'b0;
        if (h != 7'd0 && 32'(h) < LIMIT)
            r = u[HW'(h)];
        return r;
    endfunction

    assign stat.scan_done = (32'(scan_reg) >= LIMIT - 1);

    logic [19:0] gp_m, mask;
    assign mask = 20'((64'd1 << PAGE_INDEX_BITS) - 1);
    assign gp_m = gpage_reg & mask;
    logic [20:0] pages;
    assign pages = {1'b0, size_reg[21:2]} + 21'(size_reg[1:0] != 2'd0);

    assign rd_a = (func_reg == FN_MOVE) ? HW'(sh_reg) : HW'(h_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg  <= in_data[2:0];
            h_reg     <= in_data[9:3];
            size_reg  <= in_data[31:10];
            gok_reg   <= in_data[32];
            gpage_reg <= in_data[52:33];
            sh_reg    <= in_data[59:53];
            soff_reg  <= in_data[91:60];
            dh_reg    <= in_data[98:92];
            doff_reg  <= in_data[130:99];
            len_reg   <= in_data[162:131];
            scan_reg  <= 8'd1;
            first_reg <= 7'd0;
            found_reg <= 1'b0;
            nfree_reg <= 7'd0;
        end
        if (cmd.scan && 32'(scan_reg) < LIMIT)
        begin
            if (!used_reg[scan_reg[HW-1:0]])
            begin
                nfree_reg <= nfree_reg + 7'd1;
                if (!found_reg)
                begin
                    found_reg <= 1'b1;
                    first_reg <= scan_reg[6:0];
                end
            end
            scan_reg <= scan_reg + 8'd1;
        end
        if (cmd.read)
        begin
            hp_reg <= page_mem[rd_a];
            hl_reg <= lock_mem[rd_a];
            hs_reg <= size_mem[rd_a];
            dp_reg <= page_mem[HW'(dh_reg)];
            ds_reg <= size_mem[HW'(dh_reg)];
        end
        if (cmd.eval)
        begin
            out_reg <= res;
            if (wr_en)
            begin
                page_mem[wr_h] <= wr_page;
                lock_mem[wr_h] <= wr_lock;
                size_mem[wr_h] <= wr_size;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= HANDLE_COUNT'(1);
        end
        else if (cmd.eval && use_en)
        begin
            used_reg[wr_h] <= use_val;
        end
    end

    assign out_data = out_reg;

    always_comb
    begin
        st = ST_OK; o_h = '0; o_base = '0; o_dest = '0; o_lock = '0; o_nf = '0;
        o_size = '0; o_pages = '0; o_rel = '0;
        wr_en = 1'b0; use_en = 1'b0; use_val = 1'b0;
        wr_h = HW'(h_reg); wr_page = hp_reg; wr_lock = hl_reg; wr_size = hs_reg;
        hv = hok(h_reg, used_reg);
        slim = {hs_reg[21:0], 10'd0};
        dlim = {ds_reg[21:0], 10'd0};
        sa = {12'd0, soff_reg[31:16], 4'd0} + {16'd0, soff_reg[15:0]};
        da = {12'd0, doff_reg[31:16], 4'd0} + {16'd0, doff_reg[15:0]};
        rs_sum = {1'b0, sa} + {1'b0, len_reg};
        rd_sum = {1'b0, da} + {1'b0, len_reg};
        case (func_t'(func_reg))
            FN_ALLOC:
            begin
                o_pages = pages;
                if (!found_reg) st = ST_NO_HANDLES;
                else if (size_reg != 22'd0 && (!gok_reg || gp_m == 20'd0)) st = ST_NO_SPACE;
                else
                begin
                    wr_h = HW'(first_reg); wr_en = 1'b1; use_en = 1'b1; use_val = 1'b1;
                    wr_page = gp_m; wr_lock = 8'd0; wr_size = size_reg; o_h = first_reg;
                end
            end
            FN_FREE:
                if (!hv) st = ST_BAD_HANDLE;
                else if (hl_reg != 8'd0) st = ST_LOCKED;
                else
                begin
                    o_rel = hp_reg & mask; use_en = 1'b1;
                end
            FN_LOCK:
                if (!hv) st = ST_BAD_HANDLE;
                else if (hl_reg == 8'hFF) st = ST_LOCK_OVF;
                else
                begin
                    wr_en = 1'b1; wr_lock = hl_reg + 8'd1; o_base = {hp_reg & mask, 12'd0};
                end
            FN_UNLOCK:
                if (!hv) st = ST_BAD_HANDLE;
                else if (hl_reg == 8'd0) st = ST_NOT_LOCKED;
                else
                begin
                    wr_en = 1'b1; wr_lock = hl_reg - 8'd1;
                end
            FN_INFO:
                if (!hv) st = ST_BAD_HANDLE;
                else
                begin
                    o_lock = hl_reg; o_nf = nfree_reg; o_size = hs_reg;
                end
            FN_RESIZE:
            begin
                o_pages = pages;
                if (!hv) st = ST_BAD_HANDLE;
                else if (hl_reg != 8'd0) st = ST_LOCKED;
                else if (!gok_reg) st = ST_NO_SPACE;
                else
                begin
                    wr_en = 1'b1; wr_size = size_reg;
                    if (gp_m != 20'd0) wr_page = gp_m;
                end
            end
            FN_MOVE:
            begin
                if (len_reg[0]) st = ST_PARITY;
                else
                begin
                    if (sh_reg != 7'd0)
                    begin
                        if (!hok(sh_reg, used_reg)) st = ST_BAD_SRC_H;
                        else if (soff_reg >= slim) st = ST_BAD_SRC_O;
                        else if (len_reg > slim - soff_reg) st = ST_BAD_LEN;
                        else sa = {hp_reg & mask, 12'd0} + soff_reg;
                    end
                    else if (rs_sum > REAL_LIMIT) st = ST_BAD_LEN;
                    if (st == ST_OK)
                    begin
                        if (dh_reg != 7'd0)
                        begin
                            if (!hok(dh_reg, used_reg)) st = ST_BAD_DST_H;
                            else if (doff_reg >= dlim) st = ST_BAD_DST_O;
                            else if (len_reg > dlim - doff_reg) st = ST_BAD_LEN;
                            else da = {dp_reg & mask, 12'd0} + doff_reg;
                        end
                        else if (rd_sum > REAL_LIMIT) st = ST_BAD_LEN;
                    end
                    if (st == ST_OK)
                    begin
                        o_base = sa; o_dest = da;
                    end
                end
            end
            default: ;
        endcase
        res = {7'd0, o_rel, o_pages, o_size, o_nf, o_lock, o_dest, o_base, o_h, st};
    end
endmodule

/* src/extended_memory_handle_table.sv */
// Extended memory handle table: one request in, one result out per transfer.
// A request passes through the idle (load), scan, read, evaluate and output
// states; the free-handle scan tests the in-use bits of handles 1 to
// min(HANDLE_COUNT,128)-1 one entry per cycle, and the result is held until
// m_tready; the next request is taken only after the result transfer. Table
// entries are read at two addresses together in the registered read state.
// Depends on xmht_pkg, xmht_ctrl and xmht_dp.
module extended_memory_handle_table
#(
    parameter int HANDLE_COUNT = xmht_pkg::HANDLE_COUNT_DEF,
    parameter int PAGE_INDEX_BITS = xmht_pkg::PAGE_INDEX_BITS_DEF
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // func, handle, size_kb, grant_ok, grant_page, source handle, src_offset,
    // destination handle, dest_offset, move_length, unused bits
    input  logic [167:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status, handle_out, base_address, dest_address, lock_level,
    // free handle count, size_kb_out, pages_needed, release_page, zero fill
    output logic [159:0] m_tdata
);
    import xmht_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    xmht_ctrl u_ctrl
    (
        .clk(clk), .rst_n(rst_n), .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .cmd(cmd), .stat(stat)
    );

    xmht_dp #(.HANDLE_COUNT(HANDLE_COUNT), .PAGE_INDEX_BITS(PAGE_INDEX_BITS)) u_dp
    (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat),
        .in_data({88'd0, s_tdata}), .out_data(m_tdata)
    );
endmodule

/* src/xmht_checker.sv */
// Port checker for the extended memory handle table, bound to the top level.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module xmht_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [159:0] m_tdata
);
    `CHK_IMPLY(a_excl, clk, rst_n, m_tvalid, !s_tready)
    `CHK_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
    `CHK_NEXT(a_busy, clk, rst_n, s_tvalid && s_tready, !s_tready)
    `CHK_IMPLY(a_st, clk, rst_n, m_tvalid, m_tdata[3:0] <= 4'd12)
endmodule

bind extended_memory_handle_table xmht_checker u_chk
(
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
